### hw/rtl/ncc_pkg.sv
`timescale 1ns / 1ps
// ncc_pkg: shared types and codes of the nearest centroid classifier
// no dependencies; imported by the datapath and the core

package ncc_pkg;

	// operation codes carried on the op field of an item beat
	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_FEATURE = 1'b1;

	// control state of the core sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} ncc_state_t;

	// per-cluster control travelling down the distance pipeline
	typedef struct packed {
		logic valid;
		logic skip;
		logic first;
	} ncc_ctl_t;

	// status returned by the distance pipeline
	typedef struct packed {
		logic busy;
		logic wr_en;
	} ncc_stat_t;

endpackage

### hw/rtl/ncc_item_if.sv
`timescale 1ns / 1ps
// ncc_item_if: input channel of the classifier, valid/ready with item payload
// no dependencies

interface ncc_item_if #(
	parameter int CW = 3,
	parameter int FW = 5,
	parameter int VW = 16
) ();
	logic                 valid;
	logic                 ready;
	logic                 op;
	logic [CW-1:0]        cluster_index;
	logic [FW-1:0]        feature_index;
	logic signed [VW-1:0] value;
	logic                 last;

	modport source (
		output valid, op, cluster_index, feature_index, value, last,
		input  ready
	);

	modport sink (
		input  valid, op, cluster_index, feature_index, value, last,
		output ready
	);
endinterface

### hw/rtl/ncc_result_if.sv
`timescale 1ns / 1ps
// ncc_result_if: result channel of the classifier, valid/ready with result payload
// no dependencies

interface ncc_result_if #(
	parameter int CW = 3,
	parameter int DW = 37,
	parameter int SW = 4
) ();
	logic          valid;
	logic          ready;
	logic [CW-1:0] nearest_cluster;
	logic [DW-1:0] best_distance;
	logic [SW-1:0] record_slot;

	modport source (
		output valid, nearest_cluster, best_distance, record_slot,
		input  ready
	);

	modport sink (
		input  valid, nearest_cluster, best_distance, record_slot,
		output ready
	);
endinterface

### hw/rtl/nearest_centroid_classifier_core.sv
`timescale 1ns / 1ps
// nearest_centroid_classifier_core: top level of the nearest centroid classifier
// depends on ncc_pkg, ncc_item_if, ncc_result_if, ncc_ram, ncc_dist
//
//  channel  dir  beat contents
//  -------  ---  -----------------------------------------------------------
//  item     in   op, cluster_index, feature_index, value, last
//  result   out  nearest_cluster, best_distance, record_slot
//
// a centroid write goes straight into the centroid ram
// a feature element holds off the next ready until it retires, with one row
// of the centroid ram read per cycle through its single read port, then
// three pipeline stages; a last element also loads the result register,
// and waits for it while the previous result is still held
// reset clears control, the accumulator valid bits and the slot counter;
// the centroid ram is not cleared, there is no clearing pass
// a stalled result holds in its output register while items are still taken

module nearest_centroid_classifier_core import ncc_pkg::*; #(
	parameter int CLUSTER_COUNT = 8,
	parameter int FEATURE_COUNT = 21,
	parameter int RECORD_COUNT  = 16,
	parameter int VALUE_WIDTH   = 16,
	localparam int CW = $clog2(CLUSTER_COUNT),
	localparam int FW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1,
	localparam int SW = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1,
	localparam int VW = VALUE_WIDTH,
	localparam int DW = 2 * VALUE_WIDTH + $clog2(FEATURE_COUNT)
) (
	input  logic         clk,
	input  logic         arst_n,
	ncc_item_if.sink     item,
	ncc_result_if.source result
);

	localparam int TBL_DEPTH = CLUSTER_COUNT * FEATURE_COUNT;
	localparam int TW        = $clog2(TBL_DEPTH);

	// sequencer state
	ncc_state_t           state_q, state_d;
	logic [CW-1:0]        clu_q;
	logic [TW-1:0]        addr_q;
	logic signed [VW-1:0] value_q;
	logic                 skip_q;
	logic                 last_q;
	logic [SW-1:0]        slot_q;

	// issue to s1
	ncc_ctl_t             ctl_s1;
	logic [CW-1:0]        idx_s1;

	// accumulator valid bits, an invalid entry reads as zero
	logic [CLUSTER_COUNT-1:0] acc_valid_q;

	// output register
	logic                 out_valid_q;
	logic [CW-1:0]        out_cluster_q;
	logic [DW-1:0]        out_dist_q;
	logic [SW-1:0]        out_slot_q;

	logic                 accept;
	logic                 tbl_we;
	logic [TW-1:0]        tbl_waddr;
	logic                 in_range_wr;
	logic                 feat_ok;
	logic                 issue;
	logic                 last_cluster;
	logic                 emit;
	logic [VW-1:0]        tbl_rdata;
	logic [DW-1:0]        acc_rdata;
	logic [DW-1:0]        acc_masked;
	ncc_stat_t            dist_stat;
	logic [CW-1:0]        acc_widx;
	logic [DW-1:0]        acc_wdata;
	logic [CW-1:0]        best_idx;
	logic [DW-1:0]        best_dist;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid & item.ready;

	assign feat_ok     = {1'b0, item.feature_index} < (FW+1)'(FEATURE_COUNT);
	assign in_range_wr = feat_ok && ({1'b0, item.cluster_index} < (CW+1)'(CLUSTER_COUNT));
	assign tbl_we      = accept && (item.op == OP_WRITE) && in_range_wr;
	assign tbl_waddr   = TW'(item.cluster_index * FEATURE_COUNT) + TW'(item.feature_index);

	assign issue        = (state_q == ST_RUN);
	assign last_cluster = (clu_q == CW'(CLUSTER_COUNT - 1));
	assign emit         = (state_q == ST_EMIT) && (!out_valid_q || result.ready);

	// centroid table, one row per cluster, one column per feature
	ncc_ram #(
		.WIDTH (VW),
		.DEPTH (TBL_DEPTH)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (item.value),
		.raddr (addr_q),
		.rdata (tbl_rdata)
	);

	// running squared distance per cluster
	ncc_ram #(
		.WIDTH (DW),
		.DEPTH (CLUSTER_COUNT)
	) u_acc_ram (
		.clk   (clk),
		.we    (dist_stat.wr_en),
		.waddr (acc_widx),
		.wdata (acc_wdata),
		.raddr (clu_q),
		.rdata (acc_rdata)
	);

	assign acc_masked = acc_valid_q[idx_s1] ? acc_rdata : '0;

	ncc_dist #(
		.CW (CW),
		.VW (VW),
		.DW (DW)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.idx_s1    (idx_s1),
		.value     (value_q),
		.tbl_data  (tbl_rdata),
		.acc_data  (acc_masked),
		.stat      (dist_stat),
		.wr_idx    (acc_widx),
		.wr_data   (acc_wdata),
		.best_idx  (best_idx),
		.best_dist (best_dist)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && item.op == OP_FEATURE) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (last_cluster) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!dist_stat.busy) begin
					state_d = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (emit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1      <= '0;
			acc_valid_q <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			ctl_s1.valid <= issue;
			ctl_s1.skip  <= skip_q;
			ctl_s1.first <= (clu_q == '0);
			if (dist_stat.wr_en) begin
				acc_valid_q[acc_widx] <= 1'b1;
			end
			if (emit) begin
				acc_valid_q <= '0;
				slot_q      <= (slot_q == SW'(RECORD_COUNT - 1)) ? '0 : slot_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and walk registers
	always_ff @(posedge clk) begin
		idx_s1 <= clu_q;
		if (accept && item.op == OP_FEATURE) begin
			value_q <= item.value;
			skip_q  <= !feat_ok;
			last_q  <= item.last;
			clu_q   <= '0;
			addr_q  <= feat_ok ? TW'(item.feature_index) : '0;
		end else if (issue) begin
			clu_q  <= clu_q + 1'b1;
			addr_q <= skip_q ? '0 : addr_q + TW'(FEATURE_COUNT);
		end
		if (emit) begin
			out_cluster_q <= best_idx;
			out_dist_q    <= best_dist;
			out_slot_q    <= slot_q;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.nearest_cluster = out_cluster_q;
	assign result.best_distance   = out_dist_q;
	assign result.record_slot     = out_slot_q;

	// checks

	// no item is taken while the distance pipeline still holds work
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !dist_stat.busy)
		else $error("item taken while pipeline busy");

	// the walk leaves run right after the final cluster row
	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && last_cluster) |=> (state_q == ST_DRAIN))
		else $error("cluster walk overran");

	// a result only appears out of the emit step
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside emit");

	// accumulators are empty after a result is produced
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (acc_valid_q == '0))
		else $error("accumulators not cleared after result");

endmodule

### hw/rtl/ncc_ram.sv
`timescale 1ns / 1ps
// ncc_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module ncc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 168,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/ncc_dist.sv
`timescale 1ns / 1ps
// ncc_dist: squared difference, saturating accumulate and running minimum
// depends on ncc_pkg

module ncc_dist import ncc_pkg::*; #(
	parameter int CW = 3,
	parameter int VW = 16,
	parameter int DW = 37
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ncc_ctl_t             ctl_s1,
	input  logic [CW-1:0]        idx_s1,
	input  logic signed [VW-1:0] value,
	input  logic [VW-1:0]        tbl_data,
	input  logic [DW-1:0]        acc_data,
	output ncc_stat_t            stat,
	output logic [CW-1:0]        wr_idx,
	output logic [DW-1:0]        wr_data,
	output logic [CW-1:0]        best_idx,
	output logic [DW-1:0]        best_dist
);

	ncc_ctl_t            ctl_s2, ctl_s3;
	logic [CW-1:0]       idx_s2, idx_s3;
	logic [VW-1:0]       mag_s2;
	logic [2*VW-1:0]     sq_s3;
	logic [DW-1:0]       acc_s2, acc_s3;
	logic [CW-1:0]       best_idx_q;
	logic [DW-1:0]       best_dist_q;
	logic signed [VW:0]  diff;
	logic [VW:0]         mag_full;
	logic [DW:0]         sum_ext;

	// s1: difference and magnitude
	assign diff     = $signed({value[VW-1], value}) - $signed({tbl_data[VW-1], tbl_data});
	assign mag_full = diff[VW] ? (VW+1)'(-diff) : (VW+1)'(diff);

	// s3: saturating add
	assign sum_ext = {1'b0, acc_s3} + (DW+1)'(sq_s3);
	assign wr_data = sum_ext[DW] ? {DW{1'b1}} : sum_ext[DW-1:0];
	assign wr_idx  = idx_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1;
		mag_s2 <= ctl_s1.skip ? '0 : mag_full[VW-1:0];
		acc_s2 <= acc_data;
		idx_s3 <= idx_s2;
		sq_s3  <= mag_s2 * mag_s2;
		acc_s3 <= acc_s2;
		// strict compare in ascending order keeps the lowest index on a tie
		if (ctl_s3.valid && (ctl_s3.first || wr_data < best_dist_q)) begin
			best_idx_q  <= idx_s3;
			best_dist_q <= wr_data;
		end
	end

	assign stat.busy  = ctl_s1.valid | ctl_s2.valid | ctl_s3.valid;
	assign stat.wr_en = ctl_s3.valid;
	assign best_idx   = best_idx_q;
	assign best_dist  = best_dist_q;

endmodule
